>>> hdl/assert_macros.svh
// Assertion macros used by quad_face_normal.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset.
`define QFN_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define QFN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/qfn_pkg.sv
// Shared constants and types for the quad face normal block.
// No dependencies.
package qfn_pkg;

  localparam int PRESCALE_BITS = 30;
  localparam int OUT_W         = 16;

  typedef struct packed {
    logic valid;
    logic degenerate;
  } tri_stat_t;

endpackage

>>> hdl/qfn_tri.sv
// Pipelined unit normal of one triangle: cross product, prescale, square root
// and one division per component. Depends on qfn_pkg.
module qfn_tri #(
  parameter int CW = 16,
  parameter int F  = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [CW-1:0]   p [3],
  input  logic signed [CW-1:0]   q [3],
  input  logic signed [CW-1:0]   r [3],
  output qfn_pkg::tri_stat_t     stat,
  output logic signed [F+1:0]    u [3]
);
  import qfn_pkg::*;

  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int NW  = PW + 1;
  localparam int MW  = PW;
  localparam int PB  = PRESCALE_BITS;
  localparam int NSH = (MW > PB) ? $clog2(MW - PB + 1) : 0;
  localparam int SW  = 2 * PB + 2;
  localparam int RW  = SW / 2;
  localparam int QW  = F + 2;
  localparam int NDW = PB + F + 1;
  localparam int NST = 5 + NSH + 2 + RW + 1 + QW + 1;

  logic [NST-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // edge vectors
  logic signed [DW-1:0] v1 [3];
  logic signed [DW-1:0] v2 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v1[i] <= DW'(p[i]) - DW'(q[i]);
        v2[i] <= DW'(p[i]) - DW'(r[i]);
      end
    end
  end

  logic signed [PW-1:0] pr [6];
  always_ff @(posedge clk) begin
    if (en) begin
      pr[0] <= v1[1] * v2[2];
      pr[1] <= v1[2] * v2[1];
      pr[2] <= v1[2] * v2[0];
      pr[3] <= v1[0] * v2[2];
      pr[4] <= v1[0] * v2[1];
      pr[5] <= v1[1] * v2[0];
    end
  end

  logic signed [NW-1:0] n [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n[i] <= NW'(pr[2*i]) - NW'(pr[2*i+1]);
      end
    end
  end

  logic [MW-1:0] mg [3];
  logic [2:0]    mg_sg;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mg[i]    <= MW'(n[i][NW-1] ? -n[i] : n[i]);
        mg_sg[i] <= n[i][NW-1];
      end
    end
  end

  // prescale: largest magnitude brought below 2^PB, one shift bit per stage
  logic [MW-1:0] sh_m  [0:NSH][3];
  logic [MW-1:0] sh_x  [0:NSH];
  logic [2:0]    sh_sg [0:NSH];
  logic          sh_dg [0:NSH];

  logic [MW-1:0] mx01, mx;
  always_comb begin
    mx01 = (mg[0] > mg[1]) ? mg[0] : mg[1];
    mx   = (mx01 > mg[2]) ? mx01 : mg[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh_m[0]  <= mg;
      sh_x[0]  <= mx;
      sh_sg[0] <= mg_sg;
      sh_dg[0] <= (mx == '0);
    end
  end

  for (genvar t = 0; t < NSH; t++) begin : g_shift
    localparam int SHA = 1 << (NSH - 1 - t);
    logic go;
    assign go = ((sh_x[t] >> SHA) >> (PB - 1)) != '0;
    always_ff @(posedge clk) begin
      if (en) begin
        sh_x[t+1]  <= go ? (sh_x[t] >> SHA) : sh_x[t];
        for (int i = 0; i < 3; i++) begin
          sh_m[t+1][i] <= go ? (sh_m[t][i] >> SHA) : sh_m[t][i];
        end
        sh_sg[t+1] <= sh_sg[t];
        sh_dg[t+1] <= sh_dg[t];
      end
    end
  end

  logic [PB-1:0]   q_m  [3];
  logic [2*PB-1:0] q_sq [3];
  logic [2:0]      q_sg;
  logic            q_dg;
  logic [PB-1:0]   mk   [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mk[i] = PB'(sh_m[NSH][i]);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q_m[i]  <= mk[i];
        q_sq[i] <= mk[i] * mk[i];
      end
      q_sg <= sh_sg[NSH];
      q_dg <= sh_dg[NSH];
    end
  end

  // square root, one root bit per stage
  logic [SW-1:0] sr_s    [0:RW];
  logic [RW:0]   sr_rem  [0:RW];
  logic [RW-1:0] sr_root [0:RW];
  logic [PB-1:0] sr_m    [0:RW][3];
  logic [2:0]    sr_sg   [0:RW];
  logic          sr_dg   [0:RW];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_s[0]    <= SW'(q_sq[0]) + SW'(q_sq[1]) + SW'(q_sq[2]);
      sr_rem[0]  <= '0;
      sr_root[0] <= '0;
      sr_m[0]    <= q_m;
      sr_sg[0]   <= q_sg;
      sr_dg[0]   <= q_dg;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RW+2:0] cur, trial;
    logic          ge;
    always_comb begin
      cur   = {sr_rem[k], sr_s[k][SW-1 -: 2]};
      trial = {1'b0, sr_root[k], 2'b01};
      ge    = cur >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sr_rem[k+1]  <= ge ? (cur[RW:0] - trial[RW:0]) : cur[RW:0];
        sr_root[k+1] <= {sr_root[k][RW-2:0], ge};
        sr_s[k+1]    <= sr_s[k] << 2;
        sr_m[k+1]    <= sr_m[k];
        sr_sg[k+1]   <= sr_sg[k];
        sr_dg[k+1]   <= sr_dg[k];
      end
    end
  end

  // rounded division m * 2^F / L, one quotient bit per stage
  logic [RW-1:0] dv_r  [0:QW][3];
  logic [QW-1:0] dv_lo [0:QW][3];
  logic [QW-1:0] dv_q  [0:QW][3];
  logic [RW-1:0] dv_d  [0:QW];
  logic [2:0]    dv_sg [0:QW];
  logic          dv_dg [0:QW];
  logic [NDW-1:0] dn   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dn[i] = (NDW'(sr_m[RW][i]) << F) + NDW'(sr_root[RW] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_r[0][i]  <= RW'(dn[i] >> QW);
        dv_lo[0][i] <= dn[i][QW-1:0];
        dv_q[0][i]  <= '0;
      end
      dv_d[0]  <= sr_root[RW];
      dv_sg[0] <= sr_sg[RW];
      dv_dg[0] <= sr_dg[RW];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RW:0] cur [3];
    logic        ge  [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        cur[i] = {dv_r[j][i], dv_lo[j][i][QW-1]};
        ge[i]  = cur[i] >= {1'b0, dv_d[j]};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_r[j+1][i]  <= ge[i] ? RW'(cur[i] - {1'b0, dv_d[j]}) : RW'(cur[i]);
          dv_lo[j+1][i] <= dv_lo[j][i] << 1;
          dv_q[j+1][i]  <= {dv_q[j][i][QW-2:0], ge[i]};
        end
        dv_d[j+1]  <= dv_d[j];
        dv_sg[j+1] <= dv_sg[j];
        dv_dg[j+1] <= dv_dg[j];
      end
    end
  end

  localparam logic [QW-1:0] ONE = QW'(1) << F;
  logic [QW-1:0] sat [3];
  logic          dg_r;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat[i] = (dv_q[QW][i] > ONE) ? ONE : dv_q[QW][i];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u[i] <= dv_sg[QW][i] ? -$signed(sat[i]) : $signed(sat[i]);
      end
      dg_r <= dv_dg[QW];
    end
  end

  assign stat.valid      = vld[NST-1];
  assign stat.degenerate = dg_r;

endmodule

>>> hdl/quad_face_normal.sv
// Quad face normal, top level: two triangle normal pipelines, averaging
// stage and output skid buffer. Depends on qfn_pkg, qfn_tri, assert_macros.svh.
//
// Usage:
//   s_tdata carries the four corners A, B, C, D of a quad, signed Q8.8.
//   m_tdata carries the averaged unit normal in signed Q1.NORMAL_FRAC_BITS;
//   m_tuser is the degenerate flag (normal forced to zero).
//   A beat is taken when tvalid and tready are both high.
// Throughput: one face per cycle while s_tready is high. Every stage of the triangle
//   pipelines advances together; a root bit and a quotient bit per stage.
// Pipeline: NSH = clog2(2*COORD_WIDTH - 27) prescale stages (0 below 15 bits),
//   RW = 31 square root stages, QW = NORMAL_FRAC_BITS + 2 divide stages.
// Stall: the output register and a one-entry skid absorb a stalled receiver;
//   s_tready drops only while the skid holds a beat, nothing is lost.
// Reset: rst clears all valid bits; s_tready is high the cycle after.
module quad_face_normal #(
  parameter int COORD_WIDTH      = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z, zero pad
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  input  logic s_tvalid,
  output logic s_tready,
  // normal_x, normal_y, normal_z
  output logic [3*qfn_pkg::OUT_W-1:0] m_tdata,
  // degenerate
  output logic m_tuser,
  output logic m_tvalid,
  input  logic m_tready
);
  import qfn_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int F  = NORMAL_FRAC_BITS;
  localparam int SUMW = F + 3;
  localparam int AW = (SUMW > OUT_W) ? SUMW : OUT_W;
  localparam int PDW = 3 * OUT_W + 1;

  logic signed [CW-1:0] va [3], vb [3], vc [3], vd [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = s_tdata[i*CW +: CW];
      vb[i] = s_tdata[(3+i)*CW +: CW];
      vc[i] = s_tdata[(6+i)*CW +: CW];
      vd[i] = s_tdata[(9+i)*CW +: CW];
    end
  end

  logic adv;
  logic sv, ov;
  logic [PDW-1:0] sd, od;

  assign adv      = !sv;
  assign s_tready = !sv;

  tri_stat_t st0, st1;
  logic signed [F+1:0] u0 [3], u1 [3];

  qfn_tri #(.CW(CW), .F(F)) u_tri0 (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s_tvalid),
    .p(va), .q(vb), .r(vc), .stat(st0), .u(u0)
  );

  qfn_tri #(.CW(CW), .F(F)) u_tri1 (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s_tvalid),
    .p(vc), .q(vd), .r(va), .stat(st1), .u(u1)
  );

  // average, floor division by two
  logic signed [SUMW-1:0] sum [3];
  logic signed [AW-1:0]   avg [3];
  logic [PDW-1:0]         avg_d;
  logic                   pv;
  logic [PDW-1:0]         pd;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SUMW'(u0[i]) + SUMW'(u1[i]);
      avg[i] = AW'(sum[i]) >>> 1;
    end
    if (st0.degenerate || st1.degenerate) begin
      avg_d = {1'b1, {(3*OUT_W){1'b0}}};
    end else begin
      avg_d = {1'b0, avg[2][OUT_W-1:0], avg[1][OUT_W-1:0], avg[0][OUT_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (adv) begin
      pv <= st0.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pd <= avg_d;
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (m_tready) begin
        sv <= 1'b0;
      end
    end else if (!ov || m_tready) begin
      ov <= pv;
    end else if (pv) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (m_tready) begin
        od <= sd;
      end
    end else if (!ov || m_tready) begin
      od <= pd;
    end else if (pv) begin
      sd <= pd;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = od[3*OUT_W-1:0];
  assign m_tuser  = od[3*OUT_W];

`include "assert_macros.svh"

  `QFN_ASSERT(a_skid_needs_out, clk, rst, sv |-> ov, "skid holds a beat with output empty")
  `QFN_ASSERT(a_tri_lockstep, clk, rst, st0.valid == st1.valid, "triangle pipelines out of step")
  `QFN_ASSERT(a_skid_fill, clk, rst, $rose(sv) |-> $past(ov && !m_tready && pv), "skid filled without stall")
  `QFN_ASSERT(a_degen_zero, clk, rst, (ov && m_tuser) |-> (m_tdata == '0), "degenerate beat with nonzero normal")

endmodule
